// ===== rtl/flac_fhf_pkg.sv =====
// package for the flac frame header finder
// holds the maximum header size, control state codes, register indexes, lookup tables and the crc-8 step
// no dependencies
`default_nettype none

package flac_fhf_pkg;

  localparam int HDR_MAX = 16;

  typedef logic [HDR_MAX-1:0][7:0] hdr_win_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_DRAIN,
    ST_EMIT
  } fhf_state_t;

  localparam logic [1:0] CFG_CHANNELS    = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_BITS = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd2;

  function automatic logic [19:0] rate_lookup(input logic [3:0] code);
    logic [19:0] r;
    case (code)
      4'd1:    r = 20'd88200;
      4'd2:    r = 20'd176400;
      4'd3:    r = 20'd192000;
      4'd4:    r = 20'd8000;
      4'd5:    r = 20'd16000;
      4'd6:    r = 20'd22050;
      4'd7:    r = 20'd24000;
      4'd8:    r = 20'd32000;
      4'd9:    r = 20'd44100;
      4'd10:   r = 20'd48000;
      4'd11:   r = 20'd96000;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] size_lookup(input logic [2:0] code);
    logic [5:0] r;
    case (code)
      3'd1:    r = 6'd8;
      3'd2:    r = 6'd12;
      3'd4:    r = 6'd16;
      3'd5:    r = 6'd20;
      3'd6:    r = 6'd24;
      3'd7:    r = 6'd32;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // one byte of crc-8, polynomial 0x07
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/flac_frame_header_finder.sv =====
// flac frame header finder, top level
// depends on flac_fhf_pkg
//
// usage: window bytes enter on the s_ channel, one per transfer, s_tlast on the
// final byte of a window. every byte position is checked as a header start once
// it and the 15 bytes after it have arrived; after the last byte the block checks
// the starts in the window tail, then drains its check pipeline (request, parse,
// multiply, slot update), then loads the result into the m_ output register once
// the drain is done and that register is free.
// throughput: one byte per cycle inside a window; after the last byte the input
// is held by the tail sweep, the pipeline drain and the result load.
// s_tready is low from the last byte until the result is loaded.
// a stalled receiver holds the result in the output register; the next window's
// bytes are still taken, and only the following result waits for it.
// configuration writes take effect the next cycle; the user must make them
// between windows, which the block itself does not enforce.
// reset (rst, synchronous) empties the window, the candidate slots and the output.
`default_nettype none

module flac_frame_header_finder #(
  parameter int WINDOW_MAX = 98304,
  parameter int CAND_SLOTS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tlast,   // window_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // found, header_offset[16:0], first_sample[51:0], block_samples[16:0],
  // header_bytes[4:0], zero fill
  output logic [95:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  localparam int PW = $clog2(WINDOW_MAX + 1);
  localparam int CW = $clog2(CAND_SLOTS + 1);
  localparam int HM = flac_fhf_pkg::HDR_MAX;

  // configuration
  logic [3:0]  stream_channels;
  logic [5:0]  stream_sample_bits;
  logic [19:0] stream_sample_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_channels    <= 4'd2;
      stream_sample_bits <= 6'd16;
      stream_sample_rate <= 20'd44100;
    end else if (cfg_we) begin
      case (cfg_index)
        flac_fhf_pkg::CFG_CHANNELS:    stream_channels    <= cfg_data[3:0];
        flac_fhf_pkg::CFG_SAMPLE_BITS: stream_sample_bits <= cfg_data[5:0];
        flac_fhf_pkg::CFG_SAMPLE_RATE: stream_sample_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  flac_fhf_pkg::fhf_state_t state, state_next;
  logic [3:0]            flush_step, flush_step_next;
  logic [PW-1:0]         pos, pos_next;
  flac_fhf_pkg::hdr_win_t hist, hist_next;
  logic                  accept, emit;

  logic                  req_v, req_v_next;
  flac_fhf_pkg::hdr_win_t req_win;
  logic [4:0]            req_n, req_n_next;
  logic [PW-1:0]         req_s, req_s_next;

  logic                  d_v, d_ok;
  logic [35:0]           d_num;
  logic [16:0]           d_blk;
  logic                  d_fixed;
  logic [4:0]            d_len;
  logic [PW-1:0]         d_s;

  logic                  m_v, m_ok;
  logic [51:0]           m_sample;
  logic [16:0]           m_blk;
  logic [4:0]            m_len;
  logic [PW-1:0]         m_s;

  logic [PW-1:0]         c_start  [CAND_SLOTS];
  logic [PW:0]           c_end    [CAND_SLOTS];
  logic [51:0]           c_sample [CAND_SLOTS];
  logic [16:0]           c_block  [CAND_SLOTS];
  logic                  c_ok     [CAND_SLOTS];
  logic [CW-1:0]         cand_count;
  logic                  window_decided;

  logic [PW:0]           flush_pos;

  assign s_tready  = (state == flac_fhf_pkg::ST_RUN);
  assign accept    = s_tvalid && s_tready;
  assign emit      = (state == flac_fhf_pkg::ST_EMIT) && (!m_tvalid || m_tready);
  assign flush_pos = {1'b0, pos} + {{(PW-3){1'b0}}, flush_step};

  always_comb begin
    state_next      = state;
    flush_step_next = flush_step;
    pos_next        = pos;
    hist_next       = hist;
    req_v_next      = 1'b0;
    req_n_next      = 5'(HM);
    req_s_next      = pos - PW'(HM - 1);
    case (state)
      flac_fhf_pkg::ST_RUN: begin
        if (accept) begin
          if (pos < PW'(WINDOW_MAX)) begin
            hist_next  = {s_tdata, hist[HM-1:1]};
            pos_next   = pos + 1'b1;
            req_v_next = (pos >= PW'(HM - 1)) && !window_decided;
          end
          if (s_tlast) begin
            state_next      = flac_fhf_pkg::ST_FLUSH;
            flush_step_next = 4'd1;
          end
        end
      end
      flac_fhf_pkg::ST_FLUSH: begin
        hist_next       = {8'h00, hist[HM-1:1]};
        req_v_next      = (flush_pos >= (PW+1)'(HM)) && !window_decided;
        req_s_next      = PW'(flush_pos - (PW+1)'(HM));
        req_n_next      = 5'(HM) - {1'b0, flush_step};
        flush_step_next = flush_step + 1'b1;
        if (flush_step == 4'(HM - 1)) begin
          state_next = flac_fhf_pkg::ST_DRAIN;
        end
      end
      flac_fhf_pkg::ST_DRAIN: begin
        if (!req_v && !d_v && !m_v) begin
          state_next = flac_fhf_pkg::ST_EMIT;
        end
      end
      flac_fhf_pkg::ST_EMIT: begin
        if (emit) begin
          state_next = flac_fhf_pkg::ST_RUN;
          pos_next   = '0;
        end
      end
      default: state_next = flac_fhf_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= flac_fhf_pkg::ST_RUN;
      flush_step <= 4'd0;
      pos        <= '0;
      hist       <= '0;
      req_v      <= 1'b0;
    end else begin
      state      <= state_next;
      flush_step <= flush_step_next;
      pos        <= pos_next;
      hist       <= hist_next;
      req_v      <= req_v_next;
    end
  end

  always_ff @(posedge clk) begin
    req_win <= hist_next;
    req_n   <= req_n_next;
    req_s   <= req_s_next;
  end

  // header parse, req_win[0] is the first header byte
  logic        p_ok;
  logic [35:0] p_num;
  logic [16:0] p_blk;
  logic [4:0]  p_at;
  logic [2:0]  p_extra;
  logic [3:0]  p_chans;
  logic [7:0]  crc_p [HM];

  always_comb begin
    logic [3:0] bs, sr, ch;
    logic [2:0] sz;
    logic [7:0] c;
    bs = req_win[2][7:4];
    sr = req_win[2][3:0];
    ch = req_win[3][7:4];
    sz = req_win[3][3:1];
    c  = req_win[4];
    p_chans = (ch < 4'd8) ? ch + 4'd1 : 4'd2;
    p_ok = (req_n >= 5'd5) && (req_win[0] == 8'hFF) && (req_win[1][7:1] == 7'h7C)
        && (bs != 4'd0) && (sr != 4'hF) && !req_win[3][0] && (ch <= 4'd10)
        && (sz != 3'd3) && (p_chans == stream_channels)
        && ((sz == 3'd0) || (flac_fhf_pkg::size_lookup(sz) == stream_sample_bits))
        && ((sr == 4'd0) || (sr >= 4'hC)
            || (flac_fhf_pkg::rate_lookup(sr) == stream_sample_rate));
    p_extra = 3'd0;
    p_num   = {28'd0, c};
    if (c[7]) begin
      if (c[7:5] == 3'b110) begin
        p_extra = 3'd1; p_num = {31'd0, c[4:0]};
      end else if (c[7:4] == 4'b1110) begin
        p_extra = 3'd2; p_num = {32'd0, c[3:0]};
      end else if (c[7:3] == 5'b11110) begin
        p_extra = 3'd3; p_num = {33'd0, c[2:0]};
      end else if (c[7:2] == 6'b111110) begin
        p_extra = 3'd4; p_num = {34'd0, c[1:0]};
      end else if (c[7:1] == 7'b1111110) begin
        p_extra = 3'd5; p_num = {35'd0, c[0]};
      end else if (c == 8'hFE) begin
        p_extra = 3'd6; p_num = '0;
      end else begin
        p_ok = 1'b0;
      end
    end
    if (req_n < 5'd5 + {2'b0, p_extra}) p_ok = 1'b0;
    for (int k = 1; k <= 6; k++) begin
      if (3'(k) <= p_extra) begin
        if (req_win[4+k][7:6] != 2'b10) p_ok = 1'b0;
        p_num = {p_num[29:0], req_win[4+k][5:0]};
      end
    end
    p_at = 5'd5 + {2'b0, p_extra};
    case (bs)
      4'd6: begin
        if (p_at + 5'd1 > req_n) p_ok = 1'b0;
        p_blk = {9'd0, req_win[p_at[3:0]]} + 17'd1;
        p_at  = p_at + 5'd1;
      end
      4'd7: begin
        if (p_at + 5'd2 > req_n) p_ok = 1'b0;
        p_blk = {1'b0, req_win[p_at[3:0]], req_win[4'(p_at + 5'd1)]} + 17'd1;
        p_at  = p_at + 5'd2;
      end
      4'd1:                   p_blk = 17'd192;
      4'd2, 4'd3, 4'd4, 4'd5: p_blk = 17'd576 << (bs - 4'd2);
      default:                p_blk = 17'd256 << (bs - 4'd8);
    endcase
    if (sr == 4'hC) p_at = p_at + 5'd1;
    else if (sr == 4'hD || sr == 4'hE) p_at = p_at + 5'd2;
    if (p_at + 5'd1 > req_n) p_ok = 1'b0;
    else if (crc_p[p_at[3:0]] != req_win[p_at[3:0]]) p_ok = 1'b0;
  end

  always_comb begin
    crc_p[0] = 8'h00;
    for (int k = 1; k < HM; k++) begin
      crc_p[k] = flac_fhf_pkg::crc8_byte(crc_p[k-1], req_win[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
      m_v <= 1'b0;
    end else begin
      d_v <= req_v;
      m_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    d_ok     <= p_ok;
    d_num    <= p_num;
    d_blk    <= p_blk;
    d_fixed  <= !req_win[1][0];
    d_len    <= p_at + 5'd1;
    d_s      <= req_s;
    m_ok     <= d_ok;
    m_sample <= d_fixed ? 52'(d_num * d_blk) : {16'd0, d_num};
    m_blk    <= d_blk;
    m_len    <= d_len;
    m_s      <= d_s;
  end

  // candidate resolution
  logic            take;
  logic            elig   [CAND_SLOTS];
  logic            keep   [CAND_SLOTS];
  logic [CW-1:0]   rank   [CAND_SLOTS];
  logic            hit_any;
  logic [CW-1:0]   hit_idx;
  logic [CW-1:0]   n_cnt;
  logic            n_ok   [CAND_SLOTS];
  logic [PW-1:0]   n_start  [CAND_SLOTS];
  logic [PW:0]     n_end    [CAND_SLOTS];
  logic [51:0]     n_sample [CAND_SLOTS];
  logic [16:0]     n_block  [CAND_SLOTS];
  logic            decide, last_ok, add;

  assign take = m_v && m_ok && !window_decided;

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < CAND_SLOTS; i++) begin
      elig[i] = (CW'(i) < cand_count) && !c_ok[i] && (c_end[i] <= {1'b0, m_s});
      if (!hit_any && elig[i]
          && ({1'b0, m_sample} == {1'b0, c_sample[i]} + {36'd0, c_block[i]})) begin
        hit_any = 1'b1;
        hit_idx = CW'(i);
      end
    end
    n_cnt = '0;
    for (int i = 0; i < CAND_SLOTS; i++) begin
      keep[i] = (CW'(i) < cand_count)
             && (!elig[i] || (hit_any && CW'(i) == hit_idx))
             && (!hit_any || CW'(i) <= hit_idx);
      rank[i] = n_cnt;
      if (keep[i]) n_cnt = n_cnt + 1'b1;
    end
    for (int j = 0; j < CAND_SLOTS; j++) begin
      n_ok[j]     = 1'b0;
      n_start[j]  = c_start[j];
      n_end[j]    = c_end[j];
      n_sample[j] = c_sample[j];
      n_block[j]  = c_block[j];
      for (int i = 0; i < CAND_SLOTS; i++) begin
        if (keep[i] && rank[i] == CW'(j)) begin
          n_ok[j]     = c_ok[i] || (hit_any && CW'(i) == hit_idx);
          n_start[j]  = c_start[i];
          n_end[j]    = c_end[i];
          n_sample[j] = c_sample[i];
          n_block[j]  = c_block[i];
        end
      end
    end
    decide  = (n_cnt != '0) && n_ok[0];
    last_ok = 1'b0;
    for (int j = 0; j < CAND_SLOTS; j++) begin
      if (CW'(j + 1) == n_cnt) last_ok = n_ok[j];
    end
    add = !decide && (n_cnt < CW'(CAND_SLOTS)) && !last_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_count     <= '0;
      window_decided <= 1'b0;
      for (int j = 0; j < CAND_SLOTS; j++) c_ok[j] <= 1'b0;
    end else if (emit) begin
      cand_count     <= '0;
      window_decided <= 1'b0;
    end else if (take) begin
      window_decided <= decide;
      cand_count     <= add ? n_cnt + 1'b1 : n_cnt;
      for (int j = 0; j < CAND_SLOTS; j++) begin
        c_ok[j] <= n_ok[j];
        if (add && CW'(j) == n_cnt) c_ok[j] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int j = 0; j < CAND_SLOTS; j++) begin
        c_start[j]  <= n_start[j];
        c_end[j]    <= n_end[j];
        c_sample[j] <= n_sample[j];
        c_block[j]  <= n_block[j];
        if (add && CW'(j) == n_cnt) begin
          c_start[j]  <= m_s;
          c_end[j]    <= {1'b0, m_s} + {{(PW-4){1'b0}}, m_len};
          c_sample[j] <= m_sample;
          c_block[j]  <= m_blk;
        end
      end
    end
  end

  // output register
  logic        r_found;
  logic [4:0]  r_len;

  assign r_found = (cand_count != '0);
  assign r_len   = 5'(c_end[0] - {1'b0, c_start[0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= '0;
      if (r_found) begin
        m_tdata[0]     <= 1'b1;
        m_tdata[17:1]  <= 17'(c_start[0]);
        m_tdata[69:18] <= c_sample[0];
        m_tdata[86:70] <= c_block[0];
        m_tdata[91:87] <= r_len;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cand_count <= CW'(CAND_SLOTS))
    else $error("candidate count beyond slot count");

  a_decided_slot: assert property (@(posedge clk) disable iff (rst)
    window_decided |-> (cand_count != '0) && c_ok[0])
    else $error("decided window without confirmed first slot");

  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    (state == flac_fhf_pkg::ST_EMIT) |-> !req_v && !d_v && !m_v)
    else $error("result emitted with checks in flight");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> (cand_count == '0) && !window_decided && (pos == '0))
    else $error("window state not cleared after result");

endmodule

`default_nettype wire

// ===== dv/flac_fhf_checker.sv =====
// result checker for the flac frame header finder
// mirrors the header search over each window and compares every m_ transfer
// depends on flac_fhf_pkg for the register indexes
`default_nettype none

module flac_fhf_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tlast,   // window_last
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  // found, header_offset, first_sample, block_samples, header_bytes, zero fill
  input  wire logic [95:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_LIMIT = 98304;
  localparam int SLOTS = 4;

  typedef struct {
    logic        found;
    logic [16:0] offset;
    logic [51:0] first_sample;
    logic [16:0] block_samples;
    logic [4:0]  header_bytes;
  } window_result_t;

  typedef logic [7:0] hdr_bytes_t [16];

  window_result_t window_results_due[$];

  logic [3:0]  want_channels;
  logic [5:0]  want_bits;
  logic [19:0] want_rate;

  logic [7:0]  recent[16];
  int unsigned win_pos;
  int unsigned slot_start[SLOTS];
  int unsigned slot_end[SLOTS];
  logic [63:0] slot_sample[SLOTS];
  int unsigned slot_block[SLOTS];
  bit          slot_ok[SLOTS];
  int unsigned slot_count;
  bit          decided;

  function automatic logic [19:0] rate_of(input logic [3:0] code);
    logic [19:0] t[16];
    t = '{0, 88200, 176400, 192000, 8000, 16000, 22050, 24000,
          32000, 44100, 48000, 96000, 0, 0, 0, 0};
    return t[code];
  endfunction

  function automatic logic [5:0] bits_of(input logic [2:0] code);
    logic [5:0] t[8];
    t = '{0, 8, 12, 0, 16, 20, 24, 32};
    return t[code];
  endfunction

  function automatic logic [7:0] crc_of(input hdr_bytes_t h, input int unsigned n);
    logic [7:0] c;
    c = 0;
    for (int k = 0; k < n; k++) begin
      c ^= h[k];
      for (int j = 0; j < 8; j++) c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
    end
    return c;
  endfunction

  function automatic bit decode_header(input hdr_bytes_t h, input int unsigned n,
                                       output int unsigned len, output logic [63:0] smp,
                                       output int unsigned blk);
    logic [3:0] bs, sr, ch;
    logic [2:0] sz;
    logic [7:0] c;
    int unsigned chans, extra, at;
    logic [63:0] v;
    len = 0; smp = 0; blk = 0;
    if (n < 5) return 0;
    if (h[0] != 8'hFF || (h[1] & 8'hFE) != 8'hF8) return 0;
    bs = h[2][7:4]; sr = h[2][3:0]; ch = h[3][7:4]; sz = h[3][3:1];
    if (bs == 0 || sr == 4'hF || h[3][0]) return 0;
    if (ch > 10 || sz == 3) return 0;
    chans = (ch < 8) ? ch + 1 : 2;
    if (chans != want_channels) return 0;
    if (sz != 0 && bits_of(sz) != want_bits) return 0;
    if (sr != 0 && sr < 12 && rate_of(sr) != want_rate) return 0;
    c = h[4];
    if (!c[7]) begin extra = 0; v = c; end
    else if ((c & 8'hE0) == 8'hC0) begin extra = 1; v = c & 8'h1F; end
    else if ((c & 8'hF0) == 8'hE0) begin extra = 2; v = c & 8'h0F; end
    else if ((c & 8'hF8) == 8'hF0) begin extra = 3; v = c & 8'h07; end
    else if ((c & 8'hFC) == 8'hF8) begin extra = 4; v = c & 8'h03; end
    else if ((c & 8'hFE) == 8'hFC) begin extra = 5; v = c & 8'h01; end
    else if (c == 8'hFE) begin extra = 6; v = 0; end
    else return 0;
    if (n < 5 + extra) return 0;
    for (int k = 1; k <= extra; k++) begin
      if (h[4+k][7:6] != 2'b10) return 0;
      v = (v << 6) | h[4+k][5:0];
    end
    at = 5 + extra;
    if (bs == 6) begin
      if (at + 1 > n) return 0;
      blk = h[at] + 1; at += 1;
    end else if (bs == 7) begin
      if (at + 2 > n) return 0;
      blk = {h[at], h[at+1]} + 1; at += 2;
    end else if (bs == 1) blk = 192;
    else if (bs <= 5) blk = 576 << (bs - 2);
    else blk = 256 << (bs - 8);
    if (sr == 12) at += 1;
    else if (sr == 13 || sr == 14) at += 2;
    if (at + 1 > n) return 0;
    if (crc_of(h, at) != h[at]) return 0;
    smp = h[1][0] ? v : v * blk;
    len = at + 1;
    return 1;
  endfunction

  function automatic void drop_slot(input int unsigned i);
    for (int unsigned k = i; k + 1 < slot_count; k++) begin
      slot_start[k] = slot_start[k+1];
      slot_end[k] = slot_end[k+1];
      slot_sample[k] = slot_sample[k+1];
      slot_block[k] = slot_block[k+1];
      slot_ok[k] = slot_ok[k+1];
    end
    slot_count--;
  endfunction

  function automatic void add_candidate(input int unsigned s, input int unsigned len,
                                        input logic [63:0] smp, input int unsigned blk);
    int unsigned i;
    i = 0;
    while (i < slot_count) begin
      if (!slot_ok[i] && slot_end[i] <= s) begin
        if (smp == slot_sample[i] + slot_block[i]) begin
          slot_ok[i] = 1;
          slot_count = i + 1;
          break;
        end
        drop_slot(i);
        continue;
      end
      i++;
    end
    if (slot_count > 0 && slot_ok[0]) begin
      decided = 1;
      return;
    end
    if (slot_count < SLOTS && (slot_count == 0 || !slot_ok[slot_count-1])) begin
      slot_start[slot_count] = s;
      slot_end[slot_count] = s + len;
      slot_sample[slot_count] = smp;
      slot_block[slot_count] = blk;
      slot_ok[slot_count] = 0;
      slot_count++;
    end
  endfunction

  function automatic void try_start(input int unsigned s, input int unsigned limit);
    hdr_bytes_t h;
    int unsigned n, len, blk;
    logic [63:0] smp;
    if (decided || s >= limit) return;
    n = limit - s;
    if (n > 16) n = 16;
    for (int k = 0; k < 16; k++) h[k] = 0;
    for (int unsigned k = 0; k < n; k++) h[k] = recent[(s + k) % 16];
    if (decode_header(h, n, len, smp, blk)) add_candidate(s, len, smp, blk);
  endfunction

  function automatic void find_header_step(input logic [7:0] b, input logic last);
    window_result_t r;
    int unsigned s;
    if (win_pos < WIN_LIMIT) begin
      recent[win_pos % 16] = b;
      win_pos++;
      if (win_pos >= 16) try_start(win_pos - 16, win_pos);
    end
    if (!last) return;
    s = (win_pos > 15) ? win_pos - 15 : 0;
    for (; s < win_pos; s++) try_start(s, win_pos);
    if (slot_count > 0) begin
      r.found = 1;
      r.offset = 17'(slot_start[0]);
      r.first_sample = slot_sample[0][51:0];
      r.block_samples = 17'(slot_block[0]);
      r.header_bytes = 5'(slot_end[0] - slot_start[0]);
    end else begin
      r = '{0, 0, 0, 0, 0};
    end
    window_results_due.push_back(r);
    win_pos = 0;
    slot_count = 0;
    decided = 0;
  endfunction

  always @(posedge clk) begin
    window_result_t e;
    if (rst) begin
      want_channels = 2; want_bits = 16; want_rate = 44100;
      for (int k = 0; k < 16; k++) recent[k] = 0;
      win_pos = 0; slot_count = 0; decided = 0;
      window_results_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          flac_fhf_pkg::CFG_CHANNELS:    want_channels = cfg_data[3:0];
          flac_fhf_pkg::CFG_SAMPLE_BITS: want_bits = cfg_data[5:0];
          flac_fhf_pkg::CFG_SAMPLE_RATE: want_rate = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) find_header_step(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (window_results_due.size() == 0) begin
          $error("result transfer with no window pending");
          errors++;
        end else begin
          e = window_results_due.pop_front();
          if (m_tdata[0] !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, m_tdata[0]); errors++;
          end
          if (m_tdata[17:1] !== e.offset) begin
            $error("header_offset: expected %0d, got %0d", e.offset, m_tdata[17:1]);
            errors++;
          end
          if (m_tdata[69:18] !== e.first_sample) begin
            $error("first_sample: expected %0d, got %0d", e.first_sample, m_tdata[69:18]);
            errors++;
          end
          if (m_tdata[86:70] !== e.block_samples) begin
            $error("block_samples: expected %0d, got %0d", e.block_samples,
                   m_tdata[86:70]);
            errors++;
          end
          if (m_tdata[91:87] !== e.header_bytes) begin
            $error("header_bytes: expected %0d, got %0d", e.header_bytes, m_tdata[91:87]);
            errors++;
          end
        end
      end
    end
    pending = window_results_due.size();
  end

endmodule

`default_nettype wire

// ===== dv/flac_frame_header_finder_test.sv =====
// testbench top for the flac frame header finder; builds probe windows of chained and
// broken frame headers, drives them under several register settings and idle patterns;
// depends on flac_fhf_pkg, flac_fhf_checker and flac_frame_header_finder
`default_nettype none

module flac_frame_header_finder_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tlast;
  logic [7:0]  s_tdata;
  logic        m_tvalid, m_tready;
  logic [95:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;
  int          errors, pending;

  int tx_idle_pct, rx_idle_pct, rx_hold_cycles;
  logic [3:0]  cur_channels;
  logic [5:0]  cur_bits;
  logic [19:0] cur_rate;
  logic [7:0]  win[$];

  flac_frame_header_finder dut (.*);
  flac_fhf_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        m_tready <= 0;
        rx_hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_window();
    foreach (win[k]) put_byte(win[k], k == win.size() - 1);
    win.delete();
  endtask

  task automatic settle_and_configure(input logic [3:0] ch, input logic [5:0] bits,
                                      input logic [19:0] rate);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    cfg_we <= 1; cfg_index <= flac_fhf_pkg::CFG_CHANNELS; cfg_data <= 20'(ch);
    @(posedge clk);
    cfg_index <= flac_fhf_pkg::CFG_SAMPLE_BITS; cfg_data <= 20'(bits);
    @(posedge clk);
    cfg_index <= flac_fhf_pkg::CFG_SAMPLE_RATE; cfg_data <= rate;
    @(posedge clk);
    cfg_we <= 0;
    cur_channels = ch; cur_bits = bits; cur_rate = rate;
  endtask

  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
    c ^= b;
    for (int j = 0; j < 8; j++) c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
    return c;
  endfunction

  // appends one header; returns its block size
  function automatic int unsigned put_header(input bit varb, input logic [63:0] v,
                                             input logic [3:0] bs, input logic [15:0] blkm1,
                                             input bit corrupt);
    logic [7:0] h[$];
    logic [3:0] sr, ch;
    logic [2:0] sz;
    logic [19:0] rates[12];
    logic [5:0] sizes[8];
    int unsigned extra, blk;
    logic [7:0] c;
    int pick;
    rates = '{0, 88200, 176400, 192000, 8000, 16000, 22050, 24000,
              32000, 44100, 48000, 96000};
    sizes = '{0, 8, 12, 0, 16, 20, 24, 32};
    sr = 4'(12 + $urandom_range(2));
    if ($urandom_range(3) == 0) sr = 0;
    for (int k = 1; k < 12; k++) if (rates[k] == cur_rate && $urandom_range(2) != 0) sr = 4'(k);
    if (cur_channels >= 1 && cur_channels <= 8) ch = cur_channels - 4'd1;
    else ch = 4'($urandom_range(10));
    if (cur_channels == 2 && $urandom_range(1)) ch = 4'(8 + $urandom_range(2));
    sz = 0;
    for (int k = 1; k < 8; k++) if (sizes[k] == cur_bits && $urandom_range(3) != 0) sz = 3'(k);
    if (v < 64'h80) extra = 0;
    else if (v < 64'h800) extra = 1;
    else if (v < 64'h10000) extra = 2;
    else if (v < 64'h200000) extra = 3;
    else if (v < 64'h4000000) extra = 4;
    else if (v < 64'h80000000) extra = 5;
    else extra = 6;
    h.push_back(8'hFF);
    h.push_back({7'b1111100, varb});
    h.push_back({bs, sr});
    h.push_back({ch, sz, 1'b0});
    h.push_back(extra == 0 ? v[7:0] : 8'((8'hFF << (7 - extra)) | (v >> (6 * extra))));
    for (int k = extra - 1; k >= 0; k--) h.push_back({2'b10, 6'((v >> (6 * k)) & 6'h3F)});
    if (bs == 6) h.push_back(blkm1[7:0]);
    if (bs == 7) begin h.push_back(blkm1[15:8]); h.push_back(blkm1[7:0]); end
    if (sr == 12) h.push_back(8'($urandom));
    if (sr == 13 || sr == 14) begin h.push_back(8'($urandom)); h.push_back(8'($urandom)); end
    c = 0;
    foreach (h[k]) c = crc_step(c, h[k]);
    h.push_back(c);
    if (corrupt) begin
      pick = int'($urandom_range(h.size() - 1));
      h[pick] ^= 8'(8'h1 << $urandom_range(7));
    end
    foreach (h[k]) win.push_back(h[k]);
    if (bs == 1) blk = 192;
    else if (bs <= 5) blk = 576 << (bs - 2);
    else if (bs == 6) blk = blkm1[7:0] + 1;
    else if (bs == 7) blk = blkm1 + 1;
    else blk = 256 << (bs - 8);
    return blk;
  endfunction

  task automatic build_window(input int target, input bit long_form);
    bit varb;
    logic [3:0] bs;
    logic [15:0] blkm1;
    logic [63:0] v;
    int unsigned blk;
    repeat ($urandom_range(3)) win.push_back(8'($urandom));
    varb = 1'($urandom_range(1));
    bs = 4'(1 + $urandom_range(14));
    blkm1 = ($urandom_range(7) == 0) ? 16'(long_form ? 16'hFFFF : 0)
                                     : 16'($urandom_range(40));
    case ($urandom_range(3))
      0: v = varb ? {$urandom_range(15), $urandom}
                  : 64'($urandom_range(32'h7FFFFFFF - 64));
      1: v = 64'($urandom_range(5000));
      default: v = 64'($urandom_range(100));
    endcase
    while (win.size() < target) begin
      blk = put_header(varb, v, bs, blkm1, $urandom_range(9) == 0);
      repeat ($urandom_range(12)) win.push_back($urandom_range(3) == 0 ? 8'hFF : 8'($urandom));
      v = varb ? v + blk : v + 1;
      if ($urandom_range(9) == 0) v = v + 1 + $urandom_range(20);
      if (varb && bs >= 6 && $urandom_range(1)) blkm1 = 16'($urandom_range(40));
    end
  endtask

  task automatic random_windows(input int count);
    repeat (count) begin
      case ($urandom_range(9))
        0: repeat (1 + $urandom_range(30)) win.push_back(8'($urandom));
        1: build_window(1 + $urandom_range(15), 0);
        default: build_window(10 + $urandom_range(50), 0);
      endcase
      send_window();
    end
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0; s_tdata = 0; s_tlast = 0;
    cfg_we = 0; cfg_index = flac_fhf_pkg::CFG_CHANNELS; cfg_data = 0;
    tx_idle_pct = 12; rx_idle_pct = 77; rx_hold_cycles = 0;
    cur_channels = 2; cur_bits = 16; cur_rate = 44100;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: one-byte window, header sizes at both ends, cut-off header
    win.push_back(8'hFF);
    send_window();
    void'(put_header(0, 0, 4'd9, 0, 0));
    send_window();
    void'(put_header(1, 64'hF_FFFF_FFFF, 4'd7, 16'hFFFF, 0));
    void'(put_header(1, 64'hF_FFFF_FFFF + 65536, 4'd7, 16'hFFFF, 0));
    send_window();
    void'(put_header(0, 64'h7FFF_FFFF, 4'd15, 0, 0));
    void'(win.pop_back());
    send_window();
    build_window(16, 1);
    send_window();
    random_windows(5);

    settle_and_configure(1, 8, 8000);
    random_windows(4);
    settle_and_configure(8, 32, 96000);
    random_windows(4);

    tx_idle_pct = 77; rx_idle_pct = 12;
    settle_and_configure(2, 12, 88200);
    random_windows(4);
    settle_and_configure(1, 1, 1);
    rx_hold_cycles = 400;
    tx_idle_pct = 0;
    random_windows(4);
    tx_idle_pct = 77;
    settle_and_configure(15, 63, 20'hFFFFF);
    random_windows(3);

    tx_idle_pct = 0; rx_idle_pct = 0;
    settle_and_configure(2, 24, 48000);
    random_windows(5);
    settle_and_configure(2, 16, 44100);
    build_window(40, 0);
    send_window();
    random_windows(2);

    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
